@@ src/usb64d_pkg.sv @@
// Shared types, constants and the character classifier for the Base64 variant decoder (~ = 62, - = 63, _ pads).
// No dependencies.
package usb64d_pkg;

	localparam int QDEPTH = 4;
	localparam int QAW = $clog2(QDEPTH);
	localparam int QCW = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_PAD = 8'h5F;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_DASH = 8'h2D;

	// One queue entry: up to three results produced by one item.
	typedef struct packed {
		logic [2:0][7:0] data;    // data[0] goes out first
		logic [1:0]      cnt;     // number of results, 1 to 3
		logic            present;
		logic            fin;     // last result of the entry ends the text
		logic            failed;
	} usb64d_entry_t;

	typedef struct packed {
		logic       bad;
		logic [5:0] val;
	} usb64d_sextet_t;

	function automatic usb64d_sextet_t sextet_of(input logic [7:0] c);
		usb64d_sextet_t s;
		logic [7:0] t;
		s = '{bad: 1'b0, val: 6'd0};
		t = 8'd0;
		if (c >= 8'h41 && c <= 8'h5A) begin
			t = c - 8'h41;
			s.val = t[5:0];
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			t = c - 8'h61 + 8'd26;
			s.val = t[5:0];
		end else if (c >= 8'h30 && c <= 8'h39) begin
			t = c - 8'h30 + 8'd52;
			s.val = t[5:0];
		end else if (c == CH_TILDE) begin
			s.val = 6'd62;
		end else if (c == CH_DASH) begin
			s.val = 6'd63;
		end else begin
			s.bad = 1'b1;
		end
		return s;
	endfunction

endpackage

@@ src/usb64d_front.sv @@
// Front end: accepts characters, classifies them and tracks group, pad and error state.
// Pushes one queue entry per item that yields results. Depends on usb64d_pkg.
module usb64d_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [7:0]               code_char,
	input  logic                     end_of_text,
	input  logic                     char_valid,
	output logic                     char_stall,
	input  logic                     q_full,
	output logic                     push,
	output usb64d_pkg::usb64d_entry_t entry
);
	import usb64d_pkg::*;

	logic [17:0] acc_q;
	logic [1:0]  chars_q;
	logic        pad_q;
	logic        err_q;

	logic [17:0] n_acc;
	logic [1:0]  n_chars;
	logic        n_pad;
	logic        n_err;
	logic        grp_done;
	logic        has_entry;
	logic        accept;
	logic [23:0] word;
	usb64d_sextet_t sx;

	assign char_stall = q_full;
	assign accept = char_valid && !char_stall;
	assign push = accept && has_entry;

	always_comb begin
		logic is_pad;
		logic use_char;
		sx = sextet_of(code_char);
		is_pad = (code_char == CH_PAD);
		use_char = !err_q && !is_pad && !sx.bad && !pad_q;
		word = {acc_q, sx.val};
		grp_done = use_char && (chars_q == 2'd3);
		n_err = err_q || (!err_q && !is_pad && (sx.bad || pad_q));
		n_pad = pad_q || (!err_q && is_pad);
		if (grp_done) begin
			n_acc = 18'd0;
			n_chars = 2'd0;
		end else if (use_char) begin
			n_acc = {acc_q[11:0], sx.val};
			n_chars = chars_q + 2'd1;
		end else begin
			n_acc = acc_q;
			n_chars = chars_q;
		end

		entry = '{data: '0, cnt: 2'd1, present: 1'b0, fin: 1'b1, failed: 1'b0};
		has_entry = 1'b0;
		if (!end_of_text) begin
			has_entry = grp_done;
			entry.data = {word[7:0], word[15:8], word[23:16]};
			entry.cnt = 2'd3;
			entry.present = 1'b1;
			entry.fin = 1'b0;
		end else begin
			has_entry = 1'b1;
			if (n_err || n_chars == 2'd1) begin
				entry.failed = 1'b1;
			end else if (n_chars == 2'd2) begin
				entry.data = {8'd0, 8'd0, n_acc[11:4]};
				entry.present = 1'b1;
			end else if (n_chars == 2'd3) begin
				entry.data = {8'd0, n_acc[9:2], n_acc[17:10]};
				entry.cnt = 2'd2;
				entry.present = 1'b1;
			end else if (grp_done) begin
				entry.data = {word[7:0], word[15:8], word[23:16]};
				entry.cnt = 2'd3;
				entry.present = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 18'd0;
			chars_q <= 2'd0;
			pad_q <= 1'b0;
			err_q <= 1'b0;
		end else if (accept) begin
			if (end_of_text) begin
				acc_q <= 18'd0;
				chars_q <= 2'd0;
				pad_q <= 1'b0;
				err_q <= 1'b0;
			end else begin
				acc_q <= n_acc;
				chars_q <= n_chars;
				pad_q <= n_pad;
				err_q <= n_err;
			end
		end
	end

endmodule

@@ src/usb64d_fifo.sv @@
// Short entry queue between the front end and the output sequencer.
// Depends on usb64d_pkg.
module usb64d_fifo (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  usb64d_pkg::usb64d_entry_t wdata,
	output logic                     full,
	input  logic                     pop,
	output logic                     avail,
	output usb64d_pkg::usb64d_entry_t rdata
);
	import usb64d_pkg::*;

	usb64d_entry_t mem_q [QDEPTH];
	logic [QAW-1:0] wp_q;
	logic [QAW-1:0] rp_q;
	logic [QCW-1:0] cnt_q;

	assign full = (cnt_q == QCW'(QDEPTH));
	assign avail = (cnt_q != '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QAW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == QAW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop)) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> avail) else $error("queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCW'(QDEPTH)) else $error("queue count out of range");

endmodule

@@ src/usb64d_back.sv @@
// Output sequencer: unpacks queue entries into one result per cycle unless stalled,
// through an output register. Depends on usb64d_pkg.
module usb64d_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     q_avail,
	input  usb64d_pkg::usb64d_entry_t q_data,
	output logic                     pop,
	output logic [7:0]               data_byte,
	output logic                     byte_present,
	output logic                     final_result,
	output logic                     decode_failed,
	output logic                     result_valid,
	input  logic                     result_stall
);
	import usb64d_pkg::*;

	usb64d_entry_t cur_q;
	logic          cur_v_q;
	logic [1:0]    idx_q;
	logic          out_v_q;
	logic [7:0]    byte_q;
	logic          present_q;
	logic          fin_q;
	logic          failed_q;

	logic adv;
	logic last_idx;
	logic take_new;

	assign adv = cur_v_q && (!out_v_q || !result_stall);
	assign last_idx = (idx_q == cur_q.cnt - 2'd1);
	assign take_new = !cur_v_q || (adv && last_idx);
	assign pop = q_avail && take_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			idx_q <= 2'd0;
			out_v_q <= 1'b0;
		end else begin
			if (take_new) begin
				cur_v_q <= q_avail;
				idx_q <= 2'd0;
			end else if (adv) begin
				idx_q <= idx_q + 2'd1;
			end
			if (adv) begin
				out_v_q <= 1'b1;
			end else if (!result_stall) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_new) begin
			cur_q <= q_data;
		end
		if (adv) begin
			byte_q <= cur_q.present ? cur_q.data[idx_q] : 8'd0;
			present_q <= cur_q.present;
			fin_q <= cur_q.fin && last_idx;
			failed_q <= cur_q.failed;
		end
	end

	assign result_valid = out_v_q;
	assign data_byte = byte_q;
	assign byte_present = present_q;
	assign final_result = fin_q;
	assign decode_failed = failed_q;

	a_status_final: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !byte_present |-> final_result)
		else $error("status-only result not final");
	a_fail_status: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && decode_failed |-> final_result && !byte_present)
		else $error("failure flagged on a byte result");
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cur_v_q |-> cur_q.cnt != 2'd0) else $error("empty entry in sequencer");

endmodule

@@ src/url_safe_base64_decoder.sv @@
// Top level of the Base64 variant decoder (~ = 62, - = 63, _ pads): front end, entry queue and output sequencer.
// Depends on usb64d_pkg, usb64d_front, usb64d_fifo, usb64d_back.
//
//  channel   valid          stall          fields
//  char      char_valid     char_stall     code_char, end_of_text
//  result    result_valid   result_stall   data_byte, byte_present, final_result, decode_failed
//
// One character accepted per cycle while the 4-entry queue has room.
// The output sequencer sends one result per cycle unless result_stall holds it; a full group
// (4 chars, 3 bytes) drains as three results via the queue, entry and output registers.
// Reset (arst_n low) clears decode state, queue and output register.
// result_stall backs up the queue; char_stall rises when the queue is full.
module url_safe_base64_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] code_char,
	input  logic       end_of_text,
	input  logic       char_valid,
	output logic       char_stall,
	output logic [7:0] data_byte,
	output logic       byte_present,
	output logic       final_result,
	output logic       decode_failed,
	output logic       result_valid,
	input  logic       result_stall
);
	import usb64d_pkg::*;

	usb64d_entry_t wr_entry;
	usb64d_entry_t rd_entry;
	logic          push;
	logic          pop;
	logic          q_full;
	logic          q_avail;

	usb64d_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.code_char   (code_char),
		.end_of_text (end_of_text),
		.char_valid  (char_valid),
		.char_stall  (char_stall),
		.q_full      (q_full),
		.push        (push),
		.entry       (wr_entry)
	);

	usb64d_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wr_entry),
		.full   (q_full),
		.pop    (pop),
		.avail  (q_avail),
		.rdata  (rd_entry)
	);

	usb64d_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_avail       (q_avail),
		.q_data        (rd_entry),
		.pop           (pop),
		.data_byte     (data_byte),
		.byte_present  (byte_present),
		.final_result  (final_result),
		.decode_failed (decode_failed),
		.result_valid  (result_valid),
		.result_stall  (result_stall)
	);

endmodule

@@ bench/testbench.sv @@
// Testbench for url_safe_base64_decoder: directed and random encoded texts, checked by a
// scoreboard that predicts every decoded byte and final status, with random idling both ways.
// Depends on usb64d_pkg and the decoder RTL.
module testbench;
	import usb64d_pkg::*;

	localparam int QUIET_LIMIT = 5000;
	localparam int ITEM_TARGET = 330;

	typedef struct packed {
		logic [7:0] data;
		logic       present;
		logic       fin;
		logic       failed;
	} decoded_t;

	typedef enum int {TEXT_CLEAN, TEXT_CORRUPT, TEXT_NOISE} text_kind_t;

	class decode_board_t;
		logic [17:0] acc;
		logic [1:0]  grp;
		bit          pad_hit;
		bit          err_hit;
		decoded_t    due_q[$];
		int          fails;

		function new();
			restart();
			fails = 0;
		endfunction

		function void restart();
			acc = '0;
			grp = '0;
			pad_hit = 0;
			err_hit = 0;
		endfunction

		// -1 for anything outside the alphabet
		function int sextet_value(logic [7:0] c);
			int cv;
			cv = int'(c);
			if (cv >= 'h41 && cv <= 'h5A) return cv - 'h41;
			if (cv >= 'h61 && cv <= 'h7A) return cv - 'h61 + 26;
			if (cv >= 'h30 && cv <= 'h39) return cv - 'h30 + 52;
			if (c == CH_TILDE) return 62;
			if (c == CH_DASH) return 63;
			return -1;
		endfunction

		function void push(logic [7:0] d, logic p, logic f, logic e);
			due_q.push_back(decoded_t'{d, p, f, e});
		endfunction

		function void note_char(logic [7:0] c, logic eot);
			int          v;
			int          made;
			logic [23:0] word;
			made = 0;
			if (!err_hit) begin
				if (c == CH_PAD) begin
					pad_hit = 1;
				end else begin
					v = sextet_value(c);
					if (v < 0 || pad_hit) begin
						err_hit = 1;
					end else if (grp == 2'd3) begin
						word = {acc, v[5:0]};
						push(word[23:16], 1'b1, 1'b0, 1'b0);
						push(word[15:8], 1'b1, 1'b0, 1'b0);
						push(word[7:0], 1'b1, eot, 1'b0);
						made = 3;
						acc = '0;
						grp = '0;
					end else begin
						acc = {acc[11:0], v[5:0]};
						grp = grp + 2'd1;
					end
				end
			end
			if (eot) begin
				if (err_hit || grp == 2'd1)
					push(8'h00, 1'b0, 1'b1, 1'b1);
				else if (grp == 2'd2)
					push(acc[11:4], 1'b1, 1'b1, 1'b0);
				else if (grp == 2'd3) begin
					push(acc[17:10], 1'b1, 1'b0, 1'b0);
					push(acc[9:2], 1'b1, 1'b1, 1'b0);
				end else if (made == 0)
					push(8'h00, 1'b0, 1'b1, 1'b0);
				restart();
			end
		endfunction

		task report(string what);
			if (fails < 40)
				$display("MISMATCH: %s", what);
			fails++;
		endtask

		task check_result(decoded_t got);
			decoded_t want;
			if (due_q.size() == 0) begin
				report($sformatf("unexpected result data=%h present=%b final=%b failed=%b",
					got.data, got.present, got.fin, got.failed));
			end else begin
				want = due_q.pop_front();
				if (got !== want)
					report($sformatf("got data=%h present=%b final=%b failed=%b, want %h %b %b %b",
						got.data, got.present, got.fin, got.failed,
						want.data, want.present, want.fin, want.failed));
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic [7:0] code_char = 8'h00;
	logic       end_of_text = 1'b0;
	logic       char_valid = 1'b0;
	logic       char_stall;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       final_result;
	logic       decode_failed;
	logic       result_valid;
	logic       result_stall = 1'b0;

	bit            calm = 0;
	int            sent = 0;
	int            quiet = 0;
	decode_board_t board;

	url_safe_base64_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.code_char    (code_char),
		.end_of_text  (end_of_text),
		.char_valid   (char_valid),
		.char_stall   (char_stall),
		.data_byte    (data_byte),
		.byte_present (byte_present),
		.final_result (final_result),
		.decode_failed(decode_failed),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		result_stall <= !calm && $urandom_range(0, 99) < 20;
	end

	always @(posedge clk) begin
		if (arst_n && char_valid && !char_stall)
			board.note_char(code_char, end_of_text);
		if (arst_n && result_valid && !result_stall)
			board.check_result(decoded_t'{data_byte, byte_present, final_result, decode_failed});
		if (!arst_n || (char_valid && !char_stall) || (result_valid && !result_stall))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] alphabet_char(int v);
		if (v < 26) return 8'(8'h41 + v);
		if (v < 52) return 8'(8'h61 + v - 26);
		if (v < 62) return 8'(8'h30 + v - 52);
		if (v == 62) return CH_TILDE;
		return CH_DASH;
	endfunction

	task automatic send_char(logic [7:0] c, logic eot);
		if (!calm && $urandom_range(0, 99) < 10) begin
			char_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		char_valid <= 1'b1;
		code_char <= c;
		end_of_text <= eot;
		@(posedge clk);
		while (char_stall) @(posedge clk);
		sent++;
		calm = (sent >= 140 && sent < 200);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	// mostly well-formed texts, some with one bad spot, a few pure noise
	task automatic random_text();
		text_kind_t kind;
		int         roll;
		int         n;
		int         pads;
		int         bad_at;
		logic [7:0] c;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			kind = TEXT_CLEAN;
		else if (roll < 90)
			kind = TEXT_CORRUPT;
		else
			kind = TEXT_NOISE;
		n = $urandom_range(1, 13);
		pads = (kind == TEXT_NOISE) ? 0 : $urandom_range(0, 2);
		bad_at = (kind == TEXT_CORRUPT) ? $urandom_range(0, n + pads - 1) : -1;
		for (int i = 0; i < n + pads; i++) begin
			if (kind == TEXT_NOISE)
				c = 8'($urandom_range(0, 255));
			else if (i == bad_at)
				c = $urandom_range(0, 1) ? CH_PAD : 8'($urandom_range(0, 255));
			else if (i >= n)
				c = CH_PAD;
			else
				c = alphabet_char($urandom_range(0, 63));
			send_char(c, i == n + pads - 1);
		end
	endtask

	initial begin
		board = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_text("TWFu");
		send_text("~-__");
		send_text("----");
		send_text("AAA");
		send_text("B");
		send_text("_");
		send_text("Q_z");
		send_char(8'h80, 1'b1);
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b0);
		send_text("AAAA");
		while (sent < ITEM_TARGET)
			random_text();
		char_valid <= 1'b0;
		@(posedge clk);
		while (board.due_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (board.fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
